FILE: src/nrv_pkg.sv
// ---------------------------------------------------------------------------
// NRU victim select package
// Sizes, field positions, state encoding and the command and status
// bundles shared by the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package nrv_pkg;

  localparam int SETS = 1024;
  localparam int WAYS = 16;

  // Fixed widths of the request and result fields.
  localparam int SET_IN_W = 10;
  localparam int WAY_IN_W = 4;
  localparam int RND_W    = 16;
  localparam int OUT_W    = 4;

  // Request word layout in tdata, lowest bit first.
  localparam int TD_SET_LO = 0;
  localparam int TD_WAY_LO = TD_SET_LO + SET_IN_W;
  localparam int TD_HIT    = TD_WAY_LO + WAY_IN_W;
  localparam int TD_WB     = TD_HIT + 1;
  localparam int TD_RND_LO = TD_WB + 1;
  localparam int IN_DATA_W = ((TD_RND_LO + RND_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  // Derived sizes.
  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int CNT_W      = $clog2(WAYS + 1);
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = RND_W / DIV_BITS;
  localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int LANES      = 4;
  localparam int SCAN_STEPS = (WAYS + LANES - 1) / LANES;
  localparam int ZM_W       = SCAN_STEPS * LANES;
  localparam int IDX_W      = $clog2(ZM_W);

  // Request kinds carried in tuser.
  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DIV,
    ST_SCAN,
    ST_EMIT
  } nrv_state_t;

  typedef struct packed {
    logic clr_write;
    logic take;
    logic upd;
    logic load;
    logic div_run;
    logic scan;
    logic emit;
  } nrv_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_update;
    logic div_last;
    logic all_ones;
    logic found;
    logic out_busy;
  } nrv_sts_t;

endpackage

FILE: src/nrv_mod.sv
// ---------------------------------------------------------------------------
// NRU victim select remainder unit
// Restoring remainder of a random value by a small divisor, a few
// dividend bits per cycle.
// ---------------------------------------------------------------------------
module nrv_mod
  import nrv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             step,
  input  logic [RND_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             last,
  output logic [CNT_W-1:0] rem
);

  logic [RND_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RND_W-1:0]     quo_next;
  logic [CNT_W-1:0]     rem_next;

  assign last = (cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    logic [CNT_W:0] r;
    r        = {1'b0, rem};
    quo_next = quo;
    for (int k = 0; k < DIV_BITS; k++) begin
      r        = {r[CNT_W-1:0], quo_next[RND_W-1]};
      quo_next = {quo_next[RND_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    rem_next = r[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo <= dividend;
      rem <= '0;
    end else if (step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

FILE: src/nrv_ctrl.sv
// ---------------------------------------------------------------------------
// NRU victim select controller
// Sequences the clearing pass, the set lookup, the remainder, the way
// scan and the hand-over to the output register.
// ---------------------------------------------------------------------------
module nrv_ctrl
  import nrv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  nrv_sts_t sts,
  output nrv_cmd_t cmd
);

  nrv_state_t state;
  nrv_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.is_update) begin
          cmd.upd    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_next = sts.all_ones ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/nrv_dpath.sv
// ---------------------------------------------------------------------------
// NRU victim select datapath
// Used-bit memory, request registers, zero count, way scan and the
// output register.
// ---------------------------------------------------------------------------
module nrv_dpath
  import nrv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  nrv_cmd_t              cmd,
  output nrv_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  in_kind,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic [WAYS-1:0]     mem [SETS];
  logic [WAYS-1:0]     rdata;
  logic [SET_W-1:0]    clr_cnt;

  logic [SET_W-1:0]    addr;
  logic                kind;
  logic [WAY_IN_W-1:0] way;
  logic                hit;
  logic                wb;
  logic [RND_W-1:0]    rnd;

  logic                all_ones;
  logic [CNT_W-1:0]    divisor;
  logic [ZM_W-1:0]     zmask;
  logic [IDX_W-1:0]    base;
  logic [CNT_W-1:0]    rank;
  logic [IDX_W-1:0]    choice;

  logic [SET_W-1:0]    in_addr;
  logic [CNT_W-1:0]    zero_cnt;
  logic [CNT_W-1:0]    rem;
  logic                div_last;
  logic                found;
  logic [IDX_W-1:0]    pick;
  logic [CNT_W-1:0]    rank_next;
  logic                wr_en;
  logic [SET_W-1:0]    wr_addr;
  logic [WAYS-1:0]     wr_data;
  logic                upd_ok;

  // SETS is a power of two, so the set number wraps by masking.
  assign in_addr = SET_W'(32'(in_data[TD_SET_LO +: SET_IN_W]) % SETS);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      addr  <= in_addr;
      kind  <= in_kind;
      way   <= in_data[TD_WAY_LO +: WAY_IN_W];
      hit   <= in_data[TD_HIT];
      wb    <= in_data[TD_WB];
      rnd   <= in_data[TD_RND_LO +: RND_W];
      rdata <= mem[in_addr];
    end
  end

  // A writeback hit leaves the set alone, as does a way beyond the set size.
  assign upd_ok = !(hit && wb) && (32'(way) < WAYS);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = '0;
    if (cmd.clr_write) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '1;
    end else if (cmd.upd) begin
      wr_en   = upd_ok;
      wr_data = rdata | (WAYS'(1) << way);
    end else if (cmd.emit) begin
      wr_en   = all_ones;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    zero_cnt = '0;
    for (int i = 0; i < WAYS; i++) begin
      zero_cnt = zero_cnt + CNT_W'(!rdata[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      all_ones <= (zero_cnt == '0);
      divisor  <= (zero_cnt == '0) ? CNT_W'(WAYS) : zero_cnt;
      zmask    <= ZM_W'(~rdata);
      base     <= '0;
      rank     <= '0;
    end else if (cmd.scan) begin
      zmask <= zmask >> LANES;
      base  <= base + IDX_W'(LANES);
      rank  <= rank_next;
      if (found) begin
        choice <= pick;
      end
    end
  end

  nrv_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.load),
    .step     (cmd.div_run),
    .dividend (rnd),
    .divisor  (divisor),
    .last     (div_last),
    .rem      (rem)
  );

  // Walk a few ways a cycle, counting free ways until the rank matches.
  always_comb begin
    found     = 1'b0;
    pick      = '0;
    rank_next = rank;
    for (int j = 0; j < LANES; j++) begin
      if (zmask[j] && !found) begin
        if (rank_next == rem) begin
          found = 1'b1;
          pick  = base + IDX_W'(j);
        end else begin
          rank_next = rank_next + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= OUT_DATA_W'(all_ones ? OUT_W'(rem) : OUT_W'(choice));
    end
  end

  assign sts.clr_last  = (clr_cnt == SET_W'(SETS - 1));
  assign sts.is_update = (kind == CMD_UPDATE);
  assign sts.div_last  = div_last;
  assign sts.all_ones  = all_ones;
  assign sts.found     = found;
  assign sts.out_busy  = out_valid && !out_ready;

endmodule

FILE: src/nru_random_victim_select_top.sv
// ---------------------------------------------------------------------------
// NRU random victim select, top level
// Not-recently-used replacement with a random pick among the free ways.
// ---------------------------------------------------------------------------
// Requests enter on the s_ group. tuser gives the kind: victim search or
// used-bit update. A victim search returns one word on the m_ group with
// the chosen way; an update returns nothing.
// The used bits live in a single-port memory of one row per set. After
// reset the block sets every row to all ones, one row a cycle, with
// s_tready low throughout.
// An update reads the row, then writes it back with the way's bit set, except on a writeback hit.
// A victim search reads the row at the accepting edge, then counts the free
// ways, runs the remainder unit (4 bits of the random value a cycle), scans
// four ways a cycle for the chosen free way, and loads the output register.
// When no way is free the scan is skipped and the row is cleared as the
// result is loaded.
// The next request is accepted in the cycle after the current one is through,
// even while a result still waits in the output register; no new request is
// taken while a search is under way. A result that finds the output register
// full holds until m_tready frees it.
// ---------------------------------------------------------------------------
module nru_random_victim_select_top
  import nrv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // set_index[9:0], way[13:10], hit[14], is_writeback[15],
  // random_value[31:16]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // victim_way[3:0], zero fill above
  output logic [OUT_DATA_W-1:0] m_tdata
);

  nrv_cmd_t cmd;
  nrv_sts_t sts;

  nrv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nrv_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_kind   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
